@@ src/ngh_pkg.sv @@
`timescale 1ns / 1ps
package ngh_pkg;
    localparam int ALPHABET   = 26;
    localparam int SQ_SIZE    = ALPHABET * ALPHABET;
    localparam int CUBE_SIZE  = ALPHABET * ALPHABET * ALPHABET;
    localparam int CNT_W      = 16;
    localparam int LET_W      = 5;
    localparam int BIN_W      = 15;
    localparam int THR_W      = 10;
    localparam int MONO_AW    = $clog2(ALPHABET);
    localparam int DI_AW      = $clog2(SQ_SIZE);
    localparam int TRI_AW     = $clog2(CUBE_SIZE);
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_Z = 8'd90;
    localparam logic [9:0] PERMILLE = 10'd1000;
    localparam logic [THR_W-1:0] DI_THR_RST  = 10'd10;
    localparam logic [THR_W-1:0] TRI_THR_RST = 10'd4;
    localparam logic [TRI_AW-1:0] TRI_LAST = TRI_AW'(CUBE_SIZE - 1);

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_DI_THR  = 1'b0,
        REG_TRI_THR = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_LETTER = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t              op;
        logic [LET_W-1:0] letter;
        logic [1:0]       order;
        logic [BIN_W-1:0] bin;
    } cmd_t;
endpackage

@@ src/ngram_letter_histogram_top.sv @@
`timescale 1ns / 1ps
// Channel    Handshake          Fields
// input      push / full        kind, text_byte, gram_order, bin_index
// result     empty / pop        bin_count, window_total, report_flag
// config     cfg_valid/ready    cfg_index (1 bit), cfg_data (10 bit)
//
// Letter item: the back end reads the counters, then writes the increments.
// Read item: the back end fetches, compares, multiplies and flags, then holds the result until popped.
// Clear item and reset: sweep of all 17576 trigram entries, one trigram entry a cycle.
// A 4-deep command queue lets the front accept items while the back is busy.
module ngram_letter_histogram_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  text_byte,
    input  logic [1:0]  gram_order,
    input  logic [14:0] bin_index,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] bin_count,
    output logic [15:0] window_total,
    output logic        report_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);
    import ngh_pkg::*;

    cmd_t       cmd;
    logic       cmd_valid;
    logic       cmd_take;
    logic [9:0] di_thr, tri_thr;

    ngh_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .di_thr(di_thr), .tri_thr(tri_thr)
    );

    ngh_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .text_byte(text_byte), .gram_order(gram_order), .bin_index(bin_index),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    ngh_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .di_thr(di_thr), .tri_thr(tri_thr), .empty(empty),
        .pop(pop), .bin_count(bin_count), .window_total(window_total),
        .report_flag(report_flag)
    );
endmodule

@@ src/ngh_front.sv @@
`timescale 1ns / 1ps
// Classifies items, drops non-letters and unused kinds, queues commands.
module ngh_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    kind,
    input  logic [7:0]    text_byte,
    input  logic [1:0]    gram_order,
    input  logic [14:0]   bin_index,
    output logic          cmd_valid,
    output ngh_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import ngh_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    cmd_t          q_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          keep;
    logic          wr;
    logic          rd;
    cmd_t          c_in;

    always_comb
    begin
        c_in.letter = LET_W'(text_byte - CHAR_A);
        c_in.order  = gram_order;
        c_in.bin    = bin_index;
        c_in.op     = OP_LETTER;
        keep        = 1'b0;
        unique case (kind_t'(kind))
            KIND_TEXT:
            begin
                c_in.op = OP_LETTER;
                keep    = (text_byte >= CHAR_A) && (text_byte <= CHAR_Z);
            end
            KIND_READ:
            begin
                c_in.op = OP_READ;
                keep    = 1'b1;
            end
            KIND_CLEAR:
            begin
                c_in.op = OP_CLEAR;
                keep    = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign full      = (cnt_reg == (PW+1)'(DEPTH));
    assign wr        = push && !full && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign rd        = cmd_take && cmd_valid;
    assign wp_next   = wr ? wp_reg + 1'b1 : wp_reg;
    assign rp_next   = rd ? rp_reg + 1'b1 : rp_reg;
    assign cnt_next  = cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ src/ngh_back.sv @@
`timescale 1ns / 1ps
// Counter stores and read path. Letters: read then write.
// Reads: fetch, compare, multiply, flag. Clear: sweep that zeroes all three stores.
module ngh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ngh_pkg::cmd_t     cmd,
    output logic              cmd_take,
    input  logic [9:0]        di_thr,
    input  logic [9:0]        tri_thr,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       bin_count,
    output logic [15:0]       window_total,
    output logic              report_flag
);
    import ngh_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_LWR, ST_RCMP, ST_RMUL, ST_RFLAG, ST_OUT
    } bst_t;

    logic [CNT_W-1:0] mono_mem [ALPHABET];
    logic [CNT_W-1:0] di_mem   [SQ_SIZE];
    logic [CNT_W-1:0] tri_mem  [CUBE_SIZE];

    bst_t              st_reg, st_next;
    logic [TRI_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [LET_W-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic [CNT_W-1:0]  mrd_reg, drd_reg, trd_reg;
    logic [MONO_AW-1:0] ma_reg;
    logic [DI_AW-1:0]  da_reg;
    logic [TRI_AW-1:0] ta_reg;
    logic [CNT_W-1:0]  seen_reg;
    cmd_t              c_reg;
    logic              inr_reg;
    logic [CNT_W-1:0]  cnt_reg, win_reg;
    logic [25:0]       lhs_reg, rhs_reg;
    logic              flag_reg, flag_next;
    logic              take;
    logic              mono_we, di_we, tri_we, clr_we;
    logic [MONO_AW-1:0] ma;
    logic [DI_AW-1:0]  da;
    logic [TRI_AW-1:0] ta;
    logic [CNT_W-1:0]  rdv;
    logic [CNT_W:0]    win_w;
    logic [9:0]        thr;

    // addresses: letter path uses history, read path uses bin
    always_comb
    begin
        if (cmd.op == OP_READ)
        begin
            ma = MONO_AW'(cmd.bin);
            da = DI_AW'(cmd.bin);
            ta = TRI_AW'(cmd.bin);
        end
        else
        begin
            ma = MONO_AW'(cmd.letter);
            da = DI_AW'(DI_AW'(p1_reg) * DI_AW'(ALPHABET) + DI_AW'(cmd.letter));
            ta = TRI_AW'((TRI_AW'(p2_reg) * TRI_AW'(ALPHABET) + TRI_AW'(p1_reg))
                 * TRI_AW'(ALPHABET) + TRI_AW'(cmd.letter));
        end
    end

    assign mono_we = (st_reg == ST_LWR) || clr_we;
    assign di_we   = ((st_reg == ST_LWR) && seen_reg >= 16'd1) || clr_we;
    assign tri_we  = ((st_reg == ST_LWR) && seen_reg >= 16'd2) || clr_we;
    assign clr_we  = (st_reg == ST_CLR);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mrd_reg <= mono_mem[ma];
            drd_reg <= di_mem[da];
            trd_reg <= tri_mem[ta];
            ma_reg  <= ma;
            da_reg  <= da;
            ta_reg  <= ta;
            c_reg   <= cmd;
            seen_reg <= total_reg;
        end
        if (mono_we && (!clr_we || clr_reg < TRI_AW'(ALPHABET)))
        begin
            mono_mem[clr_we ? MONO_AW'(clr_reg) : ma_reg] <=
                clr_we ? '0 : (mrd_reg == COUNT_MAX ? mrd_reg : mrd_reg + 1'b1);
        end
        if (di_we && (!clr_we || clr_reg < TRI_AW'(SQ_SIZE)))
        begin
            di_mem[clr_we ? DI_AW'(clr_reg) : da_reg] <=
                clr_we ? '0 : (drd_reg == COUNT_MAX ? drd_reg : drd_reg + 1'b1);
        end
        if (tri_we)
        begin
            tri_mem[clr_we ? clr_reg : ta_reg] <=
                clr_we ? '0 : (trd_reg == COUNT_MAX ? trd_reg : trd_reg + 1'b1);
        end
    end

    // read path
    always_comb
    begin
        unique case (c_reg.order)
            2'd1:    rdv = mrd_reg;
            2'd2:    rdv = drd_reg;
            default: rdv = trd_reg;
        endcase
        win_w = {1'b0, total_reg} + 17'd1;
        thr   = (c_reg.order == 2'd2) ? di_thr : tri_thr;
        flag_next = (c_reg.order == 2'd1) ? 1'b1 :
                    (c_reg.order == 2'd0) ? 1'b0 : (lhs_reg > rhs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE)
        begin
            inr_reg <= (cmd.order == 2'd1) ? (cmd.bin < BIN_W'(ALPHABET)) :
                       (cmd.order == 2'd2) ? (cmd.bin < BIN_W'(SQ_SIZE)) :
                       (cmd.bin < BIN_W'(CUBE_SIZE));
        end
        if (st_reg == ST_RCMP)
        begin
            cnt_reg <= (inr_reg && c_reg.order != 2'd0) ? rdv : '0;
            win_reg <= (c_reg.order == 2'd0 || win_w <= 17'(c_reg.order)) ? '0 :
                       CNT_W'(win_w - 17'(c_reg.order));
        end
        if (st_reg == ST_RFLAG)
        begin
            flag_reg <= flag_next;
        end
    end

    // products settle in ST_RMUL, compared in ST_RFLAG
    always_ff @(posedge clk)
    begin
        lhs_reg <= 26'(cnt_reg) * 26'(PERMILLE);
        rhs_reg <= 26'(thr) * 26'(win_reg);
    end

    assign take         = (st_reg == ST_IDLE) && cmd_valid;
    assign cmd_take     = take;
    assign empty        = (st_reg != ST_OUT);
    assign bin_count    = cnt_reg;
    assign window_total = win_reg;
    assign report_flag  = flag_reg;

    always_comb
    begin
        st_next    = st_reg;
        clr_next   = clr_reg;
        total_next = total_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        unique case (st_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TRI_LAST)
                begin
                    st_next  = ST_IDLE;
                    clr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd.op)
                        OP_LETTER: st_next = ST_LWR;
                        OP_READ:   st_next = ST_RCMP;
                        default:
                        begin
                            st_next    = ST_CLR;
                            total_next = '0;
                            p1_next    = '0;
                            p2_next    = '0;
                        end
                    endcase
                end
            end
            ST_LWR:
            begin
                st_next    = ST_IDLE;
                total_next = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
                p2_next    = p1_reg;
                p1_next    = c_reg.letter;
            end
            ST_RCMP:  st_next = ST_RMUL;
            ST_RMUL:  st_next = ST_RFLAG;
            ST_RFLAG: st_next = ST_OUT;
            ST_OUT:   st_next = pop ? ST_IDLE : ST_OUT;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_CLR;
            clr_reg   <= '0;
            total_reg <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
        end
    end
endmodule

@@ src/ngh_cfg.sv @@
`timescale 1ns / 1ps
// Threshold registers.
module ngh_cfg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data,
    output logic [9:0] di_thr,
    output logic [9:0] tri_thr
);
    import ngh_pkg::*;

    logic [THR_W-1:0] di_reg, tri_reg;

    assign cfg_ready = 1'b1;
    assign di_thr    = di_reg;
    assign tri_thr   = tri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            di_reg  <= DI_THR_RST;
            tri_reg <= TRI_THR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DI_THR:  di_reg  <= cfg_data;
                REG_TRI_THR: tri_reg <= cfg_data;
                default:     di_reg  <= di_reg;
            endcase
        end
    end
endmodule
